[sv/i2a_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

    // Decimal digits needed for the magnitude of any 32-bit value.
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int MAG_W      = 32;
    localparam int CONV_STEPS = MAG_W;
    localparam int CNT_W      = $clog2(CONV_STEPS);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_job;

endpackage

`default_nettype wire

[sv/i2a_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface i2a_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface i2a_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] ascii_char;
    logic       last;

    modport source (output valid, output ascii_char, output last, input ready);
    modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

`default_nettype wire

[sv/i2a_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2a_front
    import i2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    i2a_in_if.sink    i_in,
    output logic      o_job_valid,
    input  wire logic i_job_ready,
    output t_job      o_job
);

    logic             r_valid;
    t_job             r_job;
    t_job             n_job;
    logic [MAG_W-1:0] w_raw;

    assign w_raw = i_in.value;

    // The magnitude is taken in unsigned arithmetic, so the most negative value
    // comes out as 2^31 without overflow.
    always_comb begin
        n_job.neg = w_raw[MAG_W-1];
        n_job.mag = w_raw[MAG_W-1] ? (MAG_W'(0) - w_raw) : w_raw;
    end

    assign i_in.ready  = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

[sv/i2a_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2a_fifo
    import i2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_job i_push_job,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_job      o_pop_job
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] n_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue fill count exceeds its depth");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr == Q_AW'(r_rd_ptr + r_count[Q_AW-1:0]))
        else $error("queue pointers disagree with the fill count");
`endif

endmodule

`default_nettype wire

[sv/i2a_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2a_back
    import i2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    output logic      o_job_ready,
    input  wire t_job i_job,
    i2a_out_if.source o_out
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    function automatic logic [3:0] digit_at(input logic [BCD_W-1:0] bcd,
                                            input logic [IDX_W-1:0] idx);
        logic [3:0] d;
        d = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (idx == IDX_W'(i)) begin
                d = bcd[4*i +: 4];
            end
        end
        return d;
    endfunction

    function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[4*i +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MAG_W-1:0]  r_shift, n_shift;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic              r_neg, n_neg;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [6:0]        r_out_char, n_out_char;
    logic              r_out_last, n_out_last;
    logic [BCD_W-1:0]  w_adj;
    logic [3:0]        w_digit;
    logic              w_out_free;

    assign o_job_ready      = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.ascii_char = r_out_char;
    assign o_out.last       = r_out_last;
    assign w_out_free       = !r_out_valid || o_out.ready;
    assign w_digit          = digit_at(r_bcd, r_idx);

    // Add-3 correction on every digit of five or more before each doubling.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                        : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_shift = i_job.mag;
                    n_neg   = i_job.neg;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd   = {w_adj[BCD_W-2:0], r_shift[MAG_W-1]};
                n_shift = {r_shift[MAG_W-2:0], 1'b0};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CONV_STEPS - 1)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Highest non-zero digit; a zero value leaves the index at the units.
                n_idx = '0;
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    if (r_bcd[4*i +: 4] != 4'd0) begin
                        n_idx = IDX_W'(i);
                    end
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        n_out_char = CHAR_MINUS;
                        n_out_last = 1'b0;
                        n_neg      = 1'b0;
                    end else begin
                        n_out_char = CHAR_ZERO + {3'b000, w_digit};
                        n_out_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_idx = r_idx - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_bcd      <= n_bcd;
        r_neg      <= n_neg;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

`ifndef SYNTHESIS
    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> bcd_ok(r_bcd))
        else $error("converted digit out of decimal range");

    a_conv_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && r_cnt == CNT_W'(CONV_STEPS - 1)) |=> (r_state == ST_SCAN))
        else $error("conversion did not finish after the last shift");
`endif

endmodule

`default_nettype wire

[sv/int32_to_decimal_ascii_core.sv]
// Signed 32-bit integer to decimal ASCII, one character per output beat.
// Values wait in a front register and a two-entry queue while the back end
// is busy; the back end runs the 32-step shift-and-add-3 conversion, then
// emits n characters (n = 1 to 11), one a cycle while the output is ready.
// Reset: synchronous active-low i_rst_n clears the queue, FSM and valids.
`timescale 1ns / 1ps
`default_nettype none

module int32_to_decimal_ascii_core
    import i2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    i2a_in_if.sink    i_in,
    i2a_out_if.source o_out
);

    logic w_f_valid;
    logic w_f_ready;
    t_job w_f_job;
    logic w_b_valid;
    logic w_b_ready;
    t_job w_b_job;

    i2a_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (w_f_valid),
        .i_job_ready (w_f_ready),
        .o_job       (w_f_job)
    );

    i2a_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_job   (w_f_job),
        .o_pop_valid  (w_b_valid),
        .i_pop_ready  (w_b_ready),
        .o_pop_job    (w_b_job)
    );

    i2a_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_b_valid),
        .o_job_ready (w_b_ready),
        .i_job       (w_b_job),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
